/* rtl/ase_pkg.sv */
// package for the arm subset execute unit: item types, codes and defaults
`default_nettype none
package ase_pkg;

    localparam int REG_COUNT_DEF = 16;
    localparam int MEM_WORDS_DEF = 8;
    localparam logic [31:0] MEM_BASE_RESET = 32'h0000_0100;
    localparam int SIGN_BIT = 31;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_AND = 4'd2;
    localparam logic [3:0] OP_ORR = 4'd3;
    localparam logic [3:0] OP_EOR = 4'd4;
    localparam logic [3:0] OP_LSL = 4'd5;
    localparam logic [3:0] OP_LSR = 4'd6;
    localparam logic [3:0] OP_MVN = 4'd7;
    localparam logic [3:0] OP_CMP = 4'd8;
    localparam logic [3:0] OP_MOV = 4'd9;
    localparam logic [3:0] OP_LDR = 4'd10;
    localparam logic [3:0] OP_STR = 4'd11;

    localparam logic [2:0] CC_AL = 3'd0;
    localparam logic [2:0] CC_EQ = 3'd1;
    localparam logic [2:0] CC_NE = 3'd2;
    localparam logic [2:0] CC_GT = 3'd3;
    localparam logic [2:0] CC_LT = 3'd4;
    localparam logic [2:0] CC_GE = 3'd5;
    localparam logic [2:0] CC_LE = 3'd6;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  cond_code;
        logic        set_flags;
        logic        use_register;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic [31:0] operand_two;
    } t_instr;

    typedef struct packed {
        logic [31:0] result_value;
        logic [3:0]  flags_nzcv;
        logic        executed;
        logic        memory_fault;
    } t_result;

endpackage
`default_nettype wire

/* rtl/ase_if.sv */
// valid/ready channel interfaces for instruction, result and configuration items
`default_nettype none
interface ase_instr_if;
    import ase_pkg::*;
    logic   valid;
    logic   ready;
    t_instr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ase_result_if;
    import ase_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ase_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/arm_subset_execute_unit_top.sv */
// top level of the arm subset execute unit
// usage:
//   i_instr  : instruction items in, accepted when valid and ready are high
//   o_result : one result item per instruction, same handshake
//   i_cfg    : write of the memory base address, always ready; write only
//              while no instruction is in flight
// an accepted item is held in an input register; once the output register is
// free or being emptied it is executed against the register file, data memory
// and flags in one pass and its result lands in the output register, from
// which o_result offers it to the receiver.
// throughput is one item per cycle while results are taken: the state
// update of one item is visible to the next one in the cycle after, with
// the single pass through the adder, shifter and memory read setting it.
// when the receiver stalls the output register holds its item, the input
// register still fills, and ready drops only while both are occupied.
// reset clears registers, data memory, flags and both valid bits and sets
// the memory base to 0x100; no clearing pass is needed.
`default_nettype none
module arm_subset_execute_unit_top #(
    parameter int REG_COUNT = ase_pkg::REG_COUNT_DEF,
    parameter int MEM_WORDS = ase_pkg::MEM_WORDS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ase_instr_if.sink    i_instr,
    ase_result_if.source o_result,
    ase_cfg_if.sink      i_cfg
);
    import ase_pkg::*;

    logic    r_in_valid, r_out_valid;
    t_instr  r_in;
    t_result r_out, exec_res;
    logic    advance;

    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_instr.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data = r_out;

    ase_core #(
        .REG_COUNT (REG_COUNT),
        .MEM_WORDS (MEM_WORDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_instr    (r_in),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_result   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_instr.valid && i_instr.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_instr.valid && i_instr.ready) begin
            r_in <= i_instr.data;
        end
        if (advance) begin
            r_out <= exec_res;
        end
    end

endmodule
`default_nettype wire

/* rtl/ase_core.sv */
// architectural state and single pass execute logic
`default_nettype none
module ase_core #(
    parameter int REG_COUNT = ase_pkg::REG_COUNT_DEF,
    parameter int MEM_WORDS = ase_pkg::MEM_WORDS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire ase_pkg::t_instr i_instr,
    input  wire logic            i_cfg_we,
    input  wire logic [31:0]     i_cfg_data,
    output ase_pkg::t_result     o_result
);
    import ase_pkg::*;

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int MIDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [31:0] REG_LIMIT = 32'(REG_COUNT);
    localparam logic [31:0] WIN_BYTES = 32'(4 * MEM_WORDS);

    logic [31:0] r_regs [REG_COUNT];
    logic [31:0] r_mem  [MEM_WORDS];
    logic [3:0]  r_flags;
    logic [31:0] r_base;

    logic [31:0] a, b, reg_b, st_data, offset, alu;
    logic [32:0] sum;
    logic        cond_ok, defined, mem_op, in_win, exe, wr_reg, upd_flags;
    logic [3:0]  n_flags;
    logic [MIDX_W-1:0] widx;
    logic [31:0] res;

    always_comb begin
        a = 32'd0;
        reg_b = 32'd0;
        st_data = 32'd0;
        if (32'(i_instr.first_reg) < REG_LIMIT) begin
            a = r_regs[i_instr.first_reg[RIDX_W-1:0]];
        end
        if (i_instr.operand_two < REG_LIMIT) begin
            reg_b = r_regs[i_instr.operand_two[RIDX_W-1:0]];
        end
        if (32'(i_instr.dest_reg) < REG_LIMIT) begin
            st_data = r_regs[i_instr.dest_reg[RIDX_W-1:0]];
        end
        b = i_instr.use_register ? reg_b : i_instr.operand_two;

        unique case (i_instr.cond_code)
            CC_AL:   cond_ok = 1'b1;
            CC_EQ:   cond_ok = r_flags[FLAG_Z];
            CC_NE:   cond_ok = !r_flags[FLAG_Z];
            CC_GT:   cond_ok = !r_flags[FLAG_Z] && (r_flags[FLAG_N] == r_flags[FLAG_V]);
            CC_LT:   cond_ok = r_flags[FLAG_N] != r_flags[FLAG_V];
            CC_GE:   cond_ok = r_flags[FLAG_N] == r_flags[FLAG_V];
            CC_LE:   cond_ok = r_flags[FLAG_Z] || (r_flags[FLAG_N] != r_flags[FLAG_V]);
            default: cond_ok = 1'b0;
        endcase

        // address register is always the operand_two index for ldr/str
        offset = reg_b - r_base;
        in_win = offset < WIN_BYTES;
        widx = offset[2 +: MIDX_W];

        sum = {1'b0, a} + {1'b0, b};
        case (i_instr.opcode)
            OP_ADD:         alu = sum[31:0];
            OP_SUB, OP_CMP: alu = a - b;
            OP_AND:         alu = a & b;
            OP_ORR:         alu = a | b;
            OP_EOR:         alu = a ^ b;
            OP_LSL:         alu = (b >= 32'd32) ? 32'd0 : (a << b[4:0]);
            OP_LSR:         alu = (b >= 32'd32) ? 32'd0 : (a >> b[4:0]);
            OP_MVN:         alu = ~b;
            OP_MOV:         alu = b;
            default:        alu = 32'd0;
        endcase

        defined = i_instr.opcode <= OP_STR;
        mem_op = (i_instr.opcode == OP_LDR) || (i_instr.opcode == OP_STR);
        exe = cond_ok && defined && (!mem_op || in_win);

        if (!exe) begin
            res = 32'd0;
        end else if (i_instr.opcode == OP_LDR) begin
            res = r_mem[widx];
        end else if (i_instr.opcode == OP_STR) begin
            res = st_data;
        end else begin
            res = alu;
        end

        wr_reg = exe && (i_instr.opcode != OP_CMP) && (i_instr.opcode != OP_STR)
                 && (32'(i_instr.dest_reg) < REG_LIMIT);
        upd_flags = exe && !mem_op && (i_instr.set_flags || (i_instr.opcode == OP_CMP));

        n_flags = r_flags;
        if (upd_flags) begin
            n_flags[FLAG_N] = alu[SIGN_BIT];
            n_flags[FLAG_Z] = alu == 32'd0;
            if (i_instr.opcode == OP_ADD) begin
                n_flags[FLAG_C] = sum[32];
                n_flags[FLAG_V] = ~(a[SIGN_BIT] ^ b[SIGN_BIT]) & (a[SIGN_BIT] ^ alu[SIGN_BIT]);
            end else if ((i_instr.opcode == OP_SUB) || (i_instr.opcode == OP_CMP)) begin
                n_flags[FLAG_C] = a >= b;
                n_flags[FLAG_V] = (a[SIGN_BIT] ^ b[SIGN_BIT]) & (a[SIGN_BIT] ^ alu[SIGN_BIT]);
            end
        end

        o_result.result_value = res;
        o_result.flags_nzcv = n_flags;
        o_result.executed = exe;
        o_result.memory_fault = cond_ok && defined && mem_op && !in_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 4'd0;
            r_base <= MEM_BASE_RESET;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= 32'd0;
            end
            for (int i = 0; i < MEM_WORDS; i++) begin
                r_mem[i] <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_advance) begin
                r_flags <= n_flags;
                if (wr_reg) begin
                    r_regs[i_instr.dest_reg[RIDX_W-1:0]] <= res;
                end
                if (exe && (i_instr.opcode == OP_STR)) begin
                    r_mem[widx] <= st_data;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ase_checker.sv */
// port level checks for the arm subset execute unit, bound to the top level
`default_nettype none
module ase_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire ase_pkg::t_result i_out_data
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result item changed while stalled");

    a_exec_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.executed && i_out_data.memory_fault))
        else $error("item both executed and faulted");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.executed |-> i_out_data.result_value == 32'd0)
        else $error("skipped item carries a value");

    // an item taken into an empty block shows as a result after passing the input and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid && $past(i_in_ready)
        && $past(i_rst_n) |=> ##1 i_out_valid)
        else $error("result item missing after acceptance");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind arm_subset_execute_unit_top ase_checker u_ase_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_instr.valid),
    .i_in_ready  (i_instr.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
`default_nettype wire

/* bench/tb_arm_subset_execute_unit_top.sv */
// testbench for the arm subset execute unit: directed and random instructions checked against a predictor
module tb_arm_subset_execute_unit_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ase_pkg::*;

    localparam int REG_COUNT = REG_COUNT_DEF;
    localparam int MEM_WORDS = MEM_WORDS_DEF;
    localparam int WINDOW_BYTES = 4 * MEM_WORDS;
    localparam int CYCLE = 8;
    localparam int LATENCY_CYCLES = 4;
    localparam int DRAIN_LIMIT = 4000;
    localparam int LONG_HOLD = 48;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int PRINT_LIMIT = 100;
    localparam logic [3:0] OP_UNDEF_FIRST = 4'd12;
    localparam logic [3:0] OP_UNDEF_LAST = 4'd15;
    localparam logic [2:0] CC_NEVER = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    logic [31:0] gpr [REG_COUNT];
    logic [31:0] dmem [MEM_WORDS];
    logic [3:0] nzcv;
    logic [31:0] mem_base;

    t_result expected_results [$];
    int unsigned error_count = 0;
    bit idle_off = 1'b0;
    int hold_request = 0;

    ase_instr_if instr_ch ();
    ase_result_if result_ch ();
    ase_cfg_if cfg_ch ();

    arm_subset_execute_unit_top DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #(CYCLE / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    function automatic void model_reset();
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        nzcv = '0;
        mem_base = MEM_BASE_RESET;
    endfunction

    function automatic logic [31:0] read_gpr(input logic [31:0] idx);
        if (idx < REG_COUNT) begin
            return gpr[idx];
        end
        return '0;
    endfunction

    // one instruction against the predicted state, returns its result item
    function automatic t_result model_execute(input t_instr x);
        t_result r;
        logic [31:0] a, b, res, off, ovf;
        logic [32:0] wide;
        logic holds;
        r = '0;
        res = '0;
        case (x.cond_code)
            CC_AL: holds = 1'b1;
            CC_EQ: holds = nzcv[FLAG_Z];
            CC_NE: holds = !nzcv[FLAG_Z];
            CC_GT: holds = !nzcv[FLAG_Z] && (nzcv[FLAG_N] == nzcv[FLAG_V]);
            CC_LT: holds = nzcv[FLAG_N] != nzcv[FLAG_V];
            CC_GE: holds = nzcv[FLAG_N] == nzcv[FLAG_V];
            CC_LE: holds = nzcv[FLAG_Z] || (nzcv[FLAG_N] != nzcv[FLAG_V]);
            default: holds = 1'b0;
        endcase
        if (holds && x.opcode <= OP_STR) begin
            a = read_gpr(32'(x.first_reg));
            b = x.use_register ? read_gpr(x.operand_two) : x.operand_two;
            r.executed = 1'b1;
            case (x.opcode)
                OP_ADD: res = a + b;
                OP_SUB, OP_CMP: res = a - b;
                OP_AND: res = a & b;
                OP_ORR: res = a | b;
                OP_EOR: res = a ^ b;
                OP_LSL: res = (b >= 32) ? '0 : (a << b[4:0]);
                OP_LSR: res = (b >= 32) ? '0 : (a >> b[4:0]);
                OP_MVN: res = ~b;
                OP_MOV: res = b;
                default: begin
                    off = read_gpr(x.operand_two) - mem_base;
                    if (off < WINDOW_BYTES) begin
                        if (x.opcode == OP_LDR) begin
                            res = dmem[off >> 2];
                            if (x.dest_reg < REG_COUNT) gpr[x.dest_reg] = res;
                        end else begin
                            res = read_gpr(32'(x.dest_reg));
                            dmem[off >> 2] = res;
                        end
                    end else begin
                        r.memory_fault = 1'b1;
                        r.executed = 1'b0;
                        res = '0;
                    end
                end
            endcase
            if (x.opcode <= OP_MOV) begin
                if (x.opcode != OP_CMP && x.dest_reg < REG_COUNT) gpr[x.dest_reg] = res;
                if (x.set_flags || x.opcode == OP_CMP) begin
                    nzcv[FLAG_N] = res[31];
                    nzcv[FLAG_Z] = (res == '0);
                    if (x.opcode == OP_ADD) begin
                        wide = {1'b0, a} + {1'b0, b};
                        ovf = ~(a ^ b) & (a ^ res);
                        nzcv[FLAG_C] = wide[32];
                        nzcv[FLAG_V] = ovf[31];
                    end else if (x.opcode == OP_SUB || x.opcode == OP_CMP) begin
                        ovf = (a ^ b) & (a ^ res);
                        nzcv[FLAG_C] = (a >= b);
                        nzcv[FLAG_V] = ovf[31];
                    end
                end
            end
            r.result_value = res;
        end
        r.flags_nzcv = nzcv;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (idle_off) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($urandom_range(0, 40));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 9))
            7: return mem_base - 32'($urandom_range(1, 8));
            8: return mem_base + WINDOW_BYTES + 32'($urandom_range(0, 8));
            9: return 32'($urandom);
            default: return mem_base + 32'(4 * $urandom_range(0, MEM_WORDS - 1))
                + 32'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic t_instr make_instr(input logic [3:0] op, input logic [2:0] cc,
                                          input logic s, input logic ur,
                                          input logic [3:0] rd, input logic [3:0] rn,
                                          input logic [31:0] op2);
        t_instr x;
        x.opcode = op;
        x.cond_code = cc;
        x.set_flags = s;
        x.use_register = ur;
        x.dest_reg = rd;
        x.first_reg = rn;
        x.operand_two = op2;
        return x;
    endfunction

    task automatic send_instr(input t_instr x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data <= x;
        do @(posedge clk); while (instr_ch.ready !== 1'b1);
        expected_results.push_back(model_execute(x));
    endtask

    task automatic drain_results();
        int waited;
        instr_ch.valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
            expected_results.delete();
        end
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_mem_base(input logic [31:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        mem_base = value;
    endtask

    task automatic send_random_item();
        t_instr x;
        int kind;
        logic [3:0] areg;
        kind = $urandom_range(0, 99);
        x.opcode = 4'($urandom_range(0, 9));
        x.cond_code = $urandom_range(0, 1) ? CC_AL : 3'($urandom_range(1, 7));
        x.set_flags = 1'($urandom);
        x.use_register = 1'($urandom);
        x.dest_reg = 4'($urandom);
        x.first_reg = 4'($urandom);
        x.operand_two = pick_value();
        if (kind < 40) begin
            x.use_register = 1'b1;
            x.operand_two = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                         : 32'($urandom_range(0, 15));
        end else if (kind < 70) begin
            x.use_register = 1'b0;
        end else if (kind < 92) begin
            // address set-up followed by a load or store through it
            areg = 4'($urandom);
            send_instr(make_instr(OP_MOV, CC_AL, 1'($urandom), 1'b0, areg, 4'($urandom),
                                  pick_address()));
            x.opcode = $urandom_range(0, 1) ? OP_LDR : OP_STR;
            x.operand_two = 32'(areg);
            if ($urandom_range(0, 3) != 0) x.cond_code = CC_AL;
        end else if (kind < 96) begin
            x.opcode = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        end else begin
            x.opcode = $urandom_range(0, 1) ? OP_LDR : OP_STR;
            x.operand_two = ($urandom_range(0, 1) == 0) ? 32'($urandom)
                                                         : 32'($urandom_range(0, 15));
        end
        send_instr(x);
    endtask

    task automatic test_arith_flags();
        send_instr(make_instr(OP_MOV, CC_AL, 1'b1, 1'b0, 4'd1, 4'd0, 32'hFFFF_FFFF));
        send_instr(make_instr(OP_MOV, CC_AL, 1'b0, 1'b0, 4'd2, 4'd0, 32'h7FFF_FFFF));
        send_instr(make_instr(OP_ADD, CC_AL, 1'b1, 1'b0, 4'd3, 4'd1, 32'd1));
        send_instr(make_instr(OP_ADD, CC_AL, 1'b1, 1'b0, 4'd4, 4'd2, 32'd1));
        send_instr(make_instr(OP_SUB, CC_AL, 1'b1, 1'b0, 4'd5, 4'd0, 32'd1));
        send_instr(make_instr(OP_CMP, CC_AL, 1'b0, 1'b1, 4'd0, 4'd2, 32'd1));
        send_instr(make_instr(OP_AND, CC_AL, 1'b1, 1'b1, 4'd6, 4'd1, 32'd2));
        send_instr(make_instr(OP_EOR, CC_AL, 1'b1, 1'b1, 4'd6, 4'd1, 32'd2));
        send_instr(make_instr(OP_ORR, CC_AL, 1'b1, 1'b0, 4'd6, 4'd0, 32'd0));
        send_instr(make_instr(OP_LSL, CC_AL, 1'b0, 1'b0, 4'd7, 4'd1, 32'd31));
        send_instr(make_instr(OP_LSL, CC_AL, 1'b1, 1'b0, 4'd7, 4'd1, 32'd32));
        send_instr(make_instr(OP_MOV, CC_AL, 1'b0, 1'b0, 4'd9, 4'd0, 32'd4));
        send_instr(make_instr(OP_LSR, CC_AL, 1'b1, 1'b1, 4'd8, 4'd1, 32'd9));
        send_instr(make_instr(OP_LSR, CC_AL, 1'b1, 1'b0, 4'd8, 4'd1, 32'hFFFF_FFFF));
        send_instr(make_instr(OP_MVN, CC_AL, 1'b1, 1'b0, 4'd10, 4'd0, 32'd0));
        // register index beyond the file reads zero
        send_instr(make_instr(OP_ADD, CC_AL, 1'b1, 1'b1, 4'd11, 4'd1, 32'hFFFF_FFFF));
        send_instr(make_instr(OP_UNDEF_LAST, CC_AL, 1'b1, 1'b0, 4'd1, 4'd1, 32'd5));
        send_instr(make_instr(OP_MOV, CC_NEVER, 1'b1, 1'b0, 4'd1, 4'd0, 32'd0));
    endtask

    task automatic test_memory();
        send_instr(make_instr(OP_MOV, CC_AL, 1'b0, 1'b0, 4'd12, 4'd0,
                              MEM_BASE_RESET + WINDOW_BYTES - 4));
        send_instr(make_instr(OP_STR, CC_AL, 1'b0, 1'b0, 4'd1, 4'd0, 32'd12));
        send_instr(make_instr(OP_LDR, CC_AL, 1'b1, 1'b0, 4'd13, 4'd0, 32'd12));
        send_instr(make_instr(OP_LDR, CC_AL, 1'b0, 1'b0, 4'd13, 4'd0, 32'd16));
        send_instr(make_instr(OP_STR, CC_AL, 1'b0, 1'b0, 4'd2, 4'd0, 32'd2));
    endtask

    task automatic test_conditions();
        send_instr(make_instr(OP_CMP, CC_AL, 1'b0, 1'b1, 4'd0, 4'd1, 32'd1));
        send_instr(make_instr(OP_MOV, CC_GT, 1'b1, 1'b0, 4'd14, 4'd0, 32'd3));
        send_instr(make_instr(OP_MOV, CC_LE, 1'b1, 1'b0, 4'd15, 4'd0, 32'h8000_0000));
    endtask

    task automatic test_base_address();
        logic [31:0] bases [4];
        bases = '{32'h0, 32'hFFFF_FFFC, 32'h0, MEM_BASE_RESET};
        bases[2] = $urandom;
        if (bases[2] > 32'hFFFF_FFFC) bases[2] = 32'hFFFF_FFFC;
        foreach (bases[i]) begin
            write_mem_base(bases[i]);
            // out-of-range address register gives address zero
            send_instr(make_instr(OP_LDR, CC_AL, 1'b0, 1'b0, 4'd3, 4'd0, 32'hFFFF_FFFF));
            repeat (100) send_random_item();
        end
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 470; i++) begin
            idle_off = (i >= 300 && i < 400);
            send_random_item();
        end
        idle_off = 1'b0;
    endtask

    task automatic test_backpressure();
        drain_results();
        idle_off = 1'b1;
        hold_request = LONG_HOLD;
        repeat (40) send_random_item();
        idle_off = 1'b0;
        drain_results();
    endtask

    initial begin : result_pacing
        int stall_left;
        int g;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    result_ch.ready <= 1'b1;
                end else begin
                    result_ch.ready <= 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_result want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item with no instruction pending");
            end else begin
                want = expected_results.pop_front();
                if (result_ch.data.result_value !== want.result_value)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              result_ch.data.result_value, want.result_value));
                if (result_ch.data.flags_nzcv !== want.flags_nzcv)
                    report_mismatch($sformatf("flags_nzcv %b, expected %b",
                                              result_ch.data.flags_nzcv, want.flags_nzcv));
                if (result_ch.data.executed !== want.executed)
                    report_mismatch($sformatf("executed %b, expected %b",
                                              result_ch.data.executed, want.executed));
                if (result_ch.data.memory_fault !== want.memory_fault)
                    report_mismatch($sformatf("memory_fault %b, expected %b",
                                              result_ch.data.memory_fault, want.memory_fault));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_arm_subset_execute_unit_top: FAIL");
        $finish;
    end

    initial begin
        instr_ch.valid <= 1'b0;
        instr_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        rst_n <= 1'b0;
        model_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_arith_flags();
        test_memory();
        test_conditions();
        test_random_mix();
        test_base_address();
        test_backpressure();
        drain_results();
        if (error_count == 0) begin
            $display("tb_arm_subset_execute_unit_top: PASS");
        end else begin
            $display("tb_arm_subset_execute_unit_top: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ase_pkg.sv
rtl/ase_if.sv
rtl/ase_core.sv
rtl/arm_subset_execute_unit_top.sv
rtl/ase_checker.sv
bench/tb_arm_subset_execute_unit_top.sv
